@@ rtl/sap_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, item type and the sRGB decode table of the alpha premultiply unit.
package sap_pkg;

    localparam int LINEAR_BITS = 16;
    localparam int LIN_W       = LINEAR_BITS + 1;
    localparam int CODE_W      = 8;
    localparam int PROD_W      = LIN_W + CODE_W;
    localparam int HALF_CODES  = 512;
    localparam int HALF_W      = $clog2(HALF_CODES);
    localparam int STEPS       = CODE_W;
    localparam int STEP_W      = $clog2(STEPS);
    localparam int BIG_W       = 384;

    localparam logic [CODE_W-1:0] UNORM_ONE = {CODE_W{1'b1}};

    typedef logic [HALF_CODES-1:0][LIN_W-1:0] lin_rom_t;

    typedef struct packed {
        logic              sat;
        logic [PROD_W-1:0] num;
        logic [CODE_W-1:0] den;
        logic [CODE_W-1:0] pos;
    } sap_item_t;

    // sRGB decode of h/510: linear segment below the knee, exact integer 2.4 power above.
    function automatic logic [LIN_W-1:0] decode_half(input int unsigned h);
        logic [BIG_W-1:0] base;
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] lhs;
        logic [63:0]      lin_num;
        logic [LIN_W-1:0] value;
        int unsigned      n;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        if (h <= 32'd20)
        begin
            lin_num = (64'(h) * 64'd20) << LINEAR_BITS;
            value   = LIN_W'((lin_num + 64'd65892) / 64'd131784);
        end
        else
        begin
            n    = 32'd100 * h + 32'd2805;
            base = BIG_W'(1);
            for (int i = 0; i < 12; i++)
            begin
                base = base * BIG_W'(53805);
            end
            rhs = BIG_W'(1) << (5 * (LINEAR_BITS + 1));
            for (int i = 0; i < 12; i++)
            begin
                rhs = rhs * BIG_W'(n);
            end
            lo = 32'd0;
            hi = 32'd1 << (LINEAR_BITS + 2);
            for (int it = 0; it < LINEAR_BITS + 4; it++)
            begin
                if (lo < hi)
                begin
                    mid = lo + ((hi - lo + 32'd1) >> 1);
                    lhs = base;
                    for (int i = 0; i < 5; i++)
                    begin
                        lhs = lhs * BIG_W'(mid);
                    end
                    if (lhs <= rhs)
                    begin
                        lo = mid;
                    end
                    else
                    begin
                        hi = mid - 32'd1;
                    end
                end
            end
            value = LIN_W'((lo + 32'd1) >> 1);
        end
        return value;
    endfunction

    function automatic lin_rom_t build_lin_rom();
        lin_rom_t rom;
        rom = '0;
        for (int h = 0; h < HALF_CODES; h++)
        begin
            rom[h] = decode_half(h);
        end
        return rom;
    endfunction

    // Even entries: decoded codes. Odd entries: thresholds between output codes.
    localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

@@ rtl/sap_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel transactions and blend result transactions.
interface sap_in_if import sap_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [CODE_W-1:0] color;
    logic [CODE_W-1:0] alpha;

    modport source (output valid, output mode, output color, output alpha, input ready);
    modport sink (input valid, input mode, input color, input alpha, output ready);
endinterface

interface sap_out_if import sap_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] result;
    logic              saturated;

    modport source (output valid, output result, output saturated, input ready);
    modport sink (input valid, input result, input saturated, output ready);
endinterface

@@ rtl/sap_decode.sv @@
`timescale 1ns / 1ps
// Front stages: sRGB decode, operand scaling and divide overflow check.
module sap_decode import sap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [CODE_W-1:0] color,
    input  logic [CODE_W-1:0] alpha,
    output logic              out_valid,
    input  logic              out_ready,
    output sap_item_t         out_item
);

    logic              v0_reg, v0_next, v1_reg, v1_next, v2_reg, v2_next;
    logic              adv0, adv1, adv2;
    logic [LIN_W-1:0]  lin_reg, lin_next;
    logic              mode_reg;
    logic [CODE_W-1:0] alpha_reg;
    logic [PROD_W-1:0] num_reg, num_next;
    logic [CODE_W-1:0] den_reg, den_next;
    logic [CODE_W-1:0] scale;
    logic              use_div;
    logic [PROD_W-1:0] top_prod;
    sap_item_t         item_reg, item_next;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign adv0     = !v0_reg || adv1;
    assign in_ready = adv0;

    always_comb
    begin
        v0_next = adv0 ? in_valid : v0_reg;
        v1_next = adv1 ? v0_reg : v1_reg;
        v2_next = adv2 ? v1_reg : v2_reg;
    end

    always_comb
    begin
        lin_next = LIN_ROM[{color, 1'b0}];
        use_div  = mode_reg && (alpha_reg != '0);
        scale    = use_div ? UNORM_ONE : alpha_reg;
        den_next = use_div ? alpha_reg : UNORM_ONE;
        num_next = PROD_W'(lin_reg) * PROD_W'(scale);
        top_prod = PROD_W'(LIN_ROM[HALF_CODES-1]) * PROD_W'(den_reg);
        item_next.sat = top_prod <= num_reg;
        item_next.num = num_reg;
        item_next.den = den_reg;
        item_next.pos = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0 && in_valid)
        begin
            lin_reg   <= lin_next;
            mode_reg  <= mode;
            alpha_reg <= alpha;
        end
        if (adv1 && v0_reg)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
        if (adv2 && v1_reg)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

    a_sat_needs_divide: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && item_reg.sat |-> item_reg.den != UNORM_ONE)
        else $error("overflow flagged without a divide by partial alpha");

endmodule

@@ rtl/sap_search_step.sv @@
`timescale 1ns / 1ps
// One stage of the binary search over the sRGB encode thresholds.
module sap_search_step import sap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [STEP_W-1:0] step,
    input  logic              in_valid,
    output logic              in_ready,
    input  sap_item_t         in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output sap_item_t         out_item
);

    logic              valid_reg, valid_next;
    logic              advance;
    logic [CODE_W-1:0] bit_mask;
    logic [CODE_W-1:0] idx;
    logic [LIN_W-1:0]  thr;
    logic [PROD_W-1:0] prod;
    logic              hit;
    sap_item_t         item_reg, item_next;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        bit_mask  = CODE_W'(1) << step;
        idx       = in_item.pos | (bit_mask - CODE_W'(1));
        thr       = LIN_ROM[{idx, 1'b1}];
        prod      = PROD_W'(thr) * PROD_W'(in_item.den);
        hit       = prod <= in_item.num;
        item_next = in_item;
        if (hit)
        begin
            item_next.pos = in_item.pos | bit_mask;
        end
        valid_next = advance ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    a_sat_clears_all: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_item.sat |-> hit)
        else $error("overflowing transaction failed a threshold compare");

endmodule

@@ rtl/srgb_alpha_premultiply_unit.sv @@
`timescale 1ns / 1ps
// Top level of the sRGB linear-light alpha premultiply / unpremultiply unit.
// One channel transaction enters per clock unless a blend stall backs up all stages;
// each passes three front stages (table decode, scaling multiply, divide overflow check)
// and eight binary-search stages that each compare one encode threshold, scaled by one
// multiplier, against the scaled linear value. Every stage has its own valid bit and moves
// as soon as the stage after it frees up, so pixel.ready drops only when all stages hold
// work and blend is stalled. The decode table is built at elaboration from LINEAR_BITS.
module srgb_alpha_premultiply_unit import sap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sap_in_if.sink     pixel,
    sap_out_if.source  blend
);

    logic [STEPS:0] chain_valid;
    logic [STEPS:0] chain_ready;
    sap_item_t      chain_item [STEPS+1];

    sap_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .mode      (pixel.mode),
        .color     (pixel.color),
        .alpha     (pixel.alpha),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_item  (chain_item[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        sap_search_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_W'(STEPS - 1 - i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    assign chain_ready[STEPS] = blend.ready;
    assign blend.valid        = chain_valid[STEPS];
    assign blend.result       = chain_item[STEPS].pos;
    assign blend.saturated    = chain_item[STEPS].sat;

    a_sat_is_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        blend.valid && blend.saturated |-> blend.result == UNORM_ONE)
        else $error("saturated transaction without full-scale result");

    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&chain_valid[STEPS:1]) && !blend.ready |-> !chain_ready[0])
        else $error("search stages full and stalled but front end may advance");

endmodule

@@ tb/tb_srgb_alpha_premultiply_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sRGB alpha premultiply unit with random idles on both channels.
module tb_srgb_alpha_premultiply_unit;
    import sap_pkg::*;

    typedef enum logic {
        PREMULTIPLY   = 1'b0,
        UNPREMULTIPLY = 1'b1
    } blend_mode_e;

    typedef struct packed {
        logic [CODE_W-1:0] result;
        logic              saturated;
    } blend_exp_t;

    typedef struct packed {
        blend_mode_e       mode;
        logic [CODE_W-1:0] color;
        logic [CODE_W-1:0] alpha;
        logic              typed;
        logic [CODE_W-1:0] result;
        logic              saturated;
    } stim_row_t;

    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM   = 1950;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{PREMULTIPLY,   8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
        '{PREMULTIPLY,   8'hff, 8'h00, 1'b1, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'hff, 8'h00, 1'b1, 8'h00, 1'b0},
        '{PREMULTIPLY,   8'hff, 8'hff, 1'b1, 8'hff, 1'b0},
        '{UNPREMULTIPLY, 8'hff, 8'hff, 1'b1, 8'hff, 1'b0},
        '{PREMULTIPLY,   8'h00, 8'hff, 1'b1, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'h00, 8'h01, 1'b1, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'hff, 8'h01, 1'b1, 8'hff, 1'b1},
        '{PREMULTIPLY,   8'h5a, 8'hff, 1'b1, 8'h5a, 1'b0},
        '{UNPREMULTIPLY, 8'ha5, 8'hff, 1'b1, 8'ha5, 1'b0},
        '{PREMULTIPLY,   8'hff, 8'h01, 1'b0, 8'h00, 1'b0},
        '{PREMULTIPLY,   8'h80, 8'h80, 1'b0, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'h80, 8'h80, 1'b0, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'h80, 8'h7f, 1'b0, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'hc0, 8'hc0, 1'b0, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'h01, 8'hfe, 1'b0, 8'h00, 1'b0},
        '{PREMULTIPLY,   8'h01, 8'h01, 1'b0, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'h0a, 8'h0b, 1'b0, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'h0b, 8'h0c, 1'b0, 8'h00, 1'b0},
        '{PREMULTIPLY,   8'hfe, 8'hfe, 1'b0, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'hfe, 8'hfe, 1'b0, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'h7f, 8'h80, 1'b0, 8'h00, 1'b0},
        '{UNPREMULTIPLY, 8'hbc, 8'hbb, 1'b0, 8'h00, 1'b0}
    };

    logic clk;
    logic rst_n;

    sap_in_if  pixel_if ();
    sap_out_if blend_if ();

    srgb_alpha_premultiply_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_if),
        .blend (blend_if)
    );

    logic [LIN_W-1:0] srgb_lin [HALF_CODES];
    blend_exp_t       pending_blends [$];
    int unsigned      mismatches;
    int unsigned      pixels_sent;
    int unsigned      unpremultiplies_sent;
    int unsigned      blends_checked;
    int unsigned      saturations_seen;
    bit               src_burst;
    bit               snk_burst;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [LIN_W-1:0] srgb_decode_half(input int unsigned h);
        logic [383:0] scale;
        logic [383:0] bound;
        logic [383:0] trial;
        logic [63:0]  ramp;
        int unsigned  y;
        int unsigned  cand;
        if (h <= 20)
        begin
            ramp = (64'(h) * 64'd20) << LINEAR_BITS;
            return LIN_W'((ramp + 64'd65892) / 64'd131784);
        end
        scale = 384'd1;
        bound = 384'd1 << (5 * (LINEAR_BITS + 1));
        for (int i = 0; i < 12; i++)
        begin
            scale = scale * 384'd53805;
            bound = bound * 384'(100 * h + 2805);
        end
        y = 0;
        for (int b = LINEAR_BITS + 2; b >= 0; b--)
        begin
            cand  = y | (32'd1 << b);
            trial = scale;
            for (int i = 0; i < 5; i++)
            begin
                trial = trial * 384'(cand);
            end
            if (trial <= bound)
            begin
                y = cand;
            end
        end
        return LIN_W'((y + 1) >> 1);
    endfunction

    function automatic blend_exp_t encode_blend(input blend_mode_e mode,
                                                input logic [CODE_W-1:0] color,
                                                input logic [CODE_W-1:0] alpha);
        blend_exp_t  p;
        logic [63:0] lin;
        logic [63:0] num;
        logic [63:0] den;
        int unsigned count;
        p = '0;
        if (alpha != '0)
        begin
            lin = 64'(srgb_lin[{color, 1'b0}]);
            if (mode == UNPREMULTIPLY)
            begin
                num = lin * 64'd255;
                den = 64'(alpha);
            end
            else
            begin
                num = lin * 64'(alpha);
                den = 64'd255;
            end
            count = 0;
            for (int k = 0; k < 255; k++)
            begin
                if (64'(srgb_lin[2 * k + 1]) * den <= num)
                begin
                    count++;
                end
            end
            p.result = CODE_W'(count);
            if (mode == UNPREMULTIPLY && 64'(srgb_lin[HALF_CODES - 1]) * den <= num)
            begin
                p.result    = UNORM_ONE;
                p.saturated = 1'b1;
            end
        end
        return p;
    endfunction

    task automatic send_pixel(input blend_mode_e mode, input logic [CODE_W-1:0] color,
                              input logic [CODE_W-1:0] alpha, input blend_exp_t want);
        int unsigned gap;
        gap = src_burst ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            pixel_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_if.valid <= 1'b1;
        pixel_if.mode  <= mode;
        pixel_if.color <= color;
        pixel_if.alpha <= alpha;
        @(posedge clk);
        while (!pixel_if.ready)
        begin
            @(posedge clk);
        end
        pending_blends.push_back(want);
        pixels_sent++;
        if (mode == UNPREMULTIPLY)
        begin
            unpremultiplies_sent++;
        end
    endtask

    initial
    begin
        int unsigned lin_color;
        int unsigned pick;
        blend_mode_e mode;
        logic [CODE_W-1:0] color;
        logic [CODE_W-1:0] alpha;
        blend_exp_t want;
        mismatches           = 0;
        pixels_sent          = 0;
        unpremultiplies_sent = 0;
        blends_checked       = 0;
        saturations_seen     = 0;
        src_burst            = 1'b0;
        snk_burst            = 1'b0;
        rst_n                = 1'b0;
        pixel_if.valid       = 1'b0;
        pixel_if.mode        = PREMULTIPLY;
        pixel_if.color       = '0;
        pixel_if.alpha       = '0;
        for (int h = 0; h < HALF_CODES; h++)
        begin
            srgb_lin[h] = srgb_decode_half(h);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].typed)
            begin
                want.result    = DIRECTED[i].result;
                want.saturated = DIRECTED[i].saturated;
            end
            else
            begin
                want = encode_blend(DIRECTED[i].mode, DIRECTED[i].color, DIRECTED[i].alpha);
            end
            send_pixel(DIRECTED[i].mode, DIRECTED[i].color, DIRECTED[i].alpha, want);
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 64 == 0)
            begin
                src_burst = ($urandom_range(0, 3) == 0);
            end
            mode = blend_mode_e'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                alpha = '0;
            end
            else if (pick < 20)
            begin
                alpha = UNORM_ONE;
            end
            else if (pick < 30)
            begin
                alpha = CODE_W'($urandom_range(1, 4));
            end
            else
            begin
                alpha = CODE_W'($urandom_range(0, 255));
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                color = (pick < 5) ? '0 : UNORM_ONE;
            end
            else if (mode == UNPREMULTIPLY && pick >= 70)
            begin
                lin_color = int'(alpha) + $urandom_range(0, 16);
                lin_color = (lin_color < 8) ? 0 : lin_color - 8;
                color     = (lin_color > 255) ? UNORM_ONE : CODE_W'(lin_color);
            end
            else
            begin
                color = CODE_W'($urandom_range(0, 255));
            end
            send_pixel(mode, color, alpha, encode_blend(mode, color, alpha));
        end
        pixel_if.valid <= 1'b0;

        while (pending_blends.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (24) @(posedge clk);

        $display("Sent %0d channel transactions (%0d unpremultiply), checked %0d results,",
                 pixels_sent, unpremultiplies_sent, blends_checked);
        $display("%0d of them clamped by divide overflow.", saturations_seen);
        if (mismatches == 0)
        begin
            $display("tb_srgb_alpha_premultiply_unit OK");
        end
        else
        begin
            $display("tb_srgb_alpha_premultiply_unit NOT OK");
        end
        $finish;
    end

    initial
    begin
        int unsigned stall;
        int unsigned taken;
        blend_exp_t want;
        blend_if.ready = 1'b0;
        taken          = 0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (taken % 64 == 0)
            begin
                snk_burst = ($urandom_range(0, 3) == 0);
            end
            stall = snk_burst ? 0 : $urandom_range(0, 17);
            if (stall != 0)
            begin
                blend_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            blend_if.ready <= 1'b1;
            @(posedge clk);
            while (!blend_if.valid)
            begin
                @(posedge clk);
            end
            taken++;
            if (pending_blends.size() == 0)
            begin
                $error("unexpected result transaction: result %0d saturated %0d",
                       blend_if.result, blend_if.saturated);
                mismatches++;
            end
            else
            begin
                want = pending_blends.pop_front();
                blends_checked++;
                if (blend_if.saturated === 1'b1)
                begin
                    saturations_seen++;
                end
                if (blend_if.result !== want.result)
                begin
                    $error("result: expected %0d, actual %0d", want.result, blend_if.result);
                    mismatches++;
                end
                if (blend_if.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0d, actual %0d",
                           want.saturated, blend_if.saturated);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding.", pending_blends.size());
        $display("tb_srgb_alpha_premultiply_unit NOT OK");
        $finish;
    end

endmodule
